/* rtl/core/hidrc_pkg.sv */
package hidrc_pkg;

  localparam int AXIS_COUNT   = 5;
  localparam int AXIS_W       = 8;
  localparam int AXES_W       = AXIS_COUNT * AXIS_W;
  localparam int HAT_W        = 4;
  localparam int BUTTON_COUNT = 12;
  localparam int BUTTON_IDX_W = 4;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [AXIS_W-1:0] AXIS_RESET = 8'h0D;

  typedef enum logic [1:0] {
    EVENT_AXES = 2'd0,
    EVENT_HAT  = 2'd1,
    EVENT_DOWN = 2'd2,
    EVENT_UP   = 2'd3
  } event_kind_t;

  // Work handed from the classifier to the event sequencer: one per report
  // that produces at least one event. Axis 0 sits in the low byte.
  typedef struct packed {
    logic [AXES_W-1:0]       axes;
    logic                    axes_chg;
    logic                    hat_chg;
    logic [HAT_W-1:0]        hat;
    logic [BUTTON_COUNT-1:0] buttons;
    logic [BUTTON_COUNT-1:0] changes;
  } work_t;

endpackage

/* rtl/core/hidrc_front.sv */
module hidrc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [hidrc_pkg::AXES_W-1:0]         in_axes,
  input  logic [7:0]                           in_hat_low,
  input  logic [7:0]                           in_high,
  input  logic                                 q_full,
  output logic                                 q_push,
  output hidrc_pkg::work_t                     q_data
);

  logic [hidrc_pkg::AXES_W-1:0]       prev_axes;
  logic [hidrc_pkg::HAT_W-1:0]        prev_hat;
  logic                               hat_seen;
  logic [hidrc_pkg::BUTTON_COUNT-1:0] prev_buttons;

  logic                               accept;
  logic [hidrc_pkg::HAT_W-1:0]        hat;
  logic [hidrc_pkg::BUTTON_COUNT-1:0] buttons;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hat      = in_hat_low[3:0];
  assign buttons  = {in_high, in_hat_low[7:4]};

  always_comb begin
    q_data.axes     = in_axes;
    q_data.axes_chg = (in_axes != prev_axes);
    // Until a hat has been seen after reset, the hat always counts as changed.
    q_data.hat_chg  = !hat_seen || (hat != prev_hat);
    q_data.hat      = hat;
    q_data.buttons  = buttons;
    q_data.changes  = buttons ^ prev_buttons;
    q_push = accept && (q_data.axes_chg || q_data.hat_chg || (q_data.changes != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_axes    <= {hidrc_pkg::AXIS_COUNT{hidrc_pkg::AXIS_RESET}};
      prev_hat     <= '0;
      hat_seen     <= 1'b0;
      prev_buttons <= '0;
    end else if (accept) begin
      if (q_data.axes_chg) begin
        prev_axes <= in_axes;
      end
      if (q_data.hat_chg) begin
        prev_hat <= hat;
        hat_seen <= 1'b1;
      end
      prev_buttons <= buttons;
    end
  end

endmodule

/* rtl/core/hidrc_queue.sv */
module hidrc_queue #(
  parameter int DEPTH = hidrc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hidrc_pkg::work_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output hidrc_pkg::work_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hidrc_pkg::work_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/hidrc_back.sv */
module hidrc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  hidrc_pkg::work_t             q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hidrc_pkg::event_kind_t       out_kind,
  output logic [3:0]                   out_value,
  output logic [hidrc_pkg::AXES_W-1:0] out_axes,
  output logic                         out_last
);

  hidrc_pkg::work_t                   cur;
  logic                               busy;

  logic                               adv;
  logic                               emit;
  logic [hidrc_pkg::BUTTON_COUNT-1:0] low;
  logic [hidrc_pkg::BUTTON_COUNT-1:0] rest;
  logic [hidrc_pkg::BUTTON_IDX_W-1:0] idx;
  hidrc_pkg::event_kind_t             ev_kind;
  logic [3:0]                         ev_value;
  logic [hidrc_pkg::AXES_W-1:0]       ev_axes;
  logic                               ev_last;

  always_comb begin
    low  = cur.changes & (~cur.changes + 1'b1);
    rest = cur.changes & ~low;
    idx  = '0;
    for (int i = hidrc_pkg::BUTTON_COUNT - 1; i >= 0; i--) begin
      if (cur.changes[i]) begin
        idx = hidrc_pkg::BUTTON_IDX_W'(i);
      end
    end
    ev_axes  = '0;
    ev_value = '0;
    priority if (cur.axes_chg) begin
      ev_kind = hidrc_pkg::EVENT_AXES;
      ev_axes = cur.axes;
      ev_last = !cur.hat_chg && (cur.changes == '0);
    end else if (cur.hat_chg) begin
      ev_kind  = hidrc_pkg::EVENT_HAT;
      ev_value = cur.hat;
      ev_last  = (cur.changes == '0);
    end else begin
      ev_kind  = ((cur.buttons & low) != '0) ? hidrc_pkg::EVENT_DOWN : hidrc_pkg::EVENT_UP;
      ev_value = 4'(idx + 1'b1);
      ev_last  = (rest == '0);
    end
  end

  assign adv   = !out_valid || out_ready;
  assign emit  = busy && adv;
  assign q_pop = q_valid && (!busy || (emit && ev_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
      end else if (emit && ev_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind  <= ev_kind;
      out_value <= ev_value;
      out_axes  <= ev_axes;
      out_last  <= ev_last;
    end
    if (q_pop) begin
      cur <= q_data;
    end else if (emit) begin
      priority if (cur.axes_chg) begin
        cur.axes_chg <= 1'b0;
      end else if (cur.hat_chg) begin
        cur.hat_chg <= 1'b0;
      end else begin
        cur.changes <= rest;
      end
    end
  end

  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cur.axes_chg || cur.hat_chg || (cur.changes != '0)))
    else $error("sequencer busy with no event left");

  a_axes_only_on_axes_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind != hidrc_pkg::EVENT_AXES)) |-> (out_axes == '0))
    else $error("axis bytes on a non-axes event");

  a_stay_busy_midway: assert property (@(posedge clk) disable iff (rst)
    (emit && !ev_last) |=> busy)
    else $error("sequencer dropped a report before its last event");

  a_axes_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == hidrc_pkg::EVENT_AXES)) |-> (out_value == '0))
    else $error("nonzero value on an axes event");

endmodule

/* rtl/core/hid_report_change_events.sv */
// Path: the first event of a report passes the work queue, the current-report
// register and the output register; its further events follow one per cycle
// while m_tready is high. Throughput: one report per cycle accepted while the
// work queue has room; a queued report yields 1 to 14 events, one per transfer.
// Reset (rst, synchronous, active high): stored axes 0x0D each, hat unseen,
// button mask zero, work queue and output register empty.
module hid_report_change_events #(
  parameter int QUEUE_DEPTH = hidrc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // axis_x[7:0], axis_y[15:8], axis_z1[23:16], axis_z2[31:24], axis_rz[39:32],
  // hat_and_low_buttons[47:40], high_buttons[55:48]
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // event_kind[1:0], event_value[5:2], out_x[13:6], out_y[21:14],
  // out_z1[29:22], out_z2[37:30], out_rz[45:38], zero[47:46]
  output logic [47:0] m_tdata,
  // last_event: final event of this report
  output logic        m_tlast
);

  logic                         q_full;
  logic                         q_push;
  logic                         q_pop;
  logic                         q_valid;
  hidrc_pkg::work_t             q_in;
  hidrc_pkg::work_t             q_out;
  hidrc_pkg::event_kind_t       out_kind;
  logic [3:0]                   out_value;
  logic [hidrc_pkg::AXES_W-1:0] out_axes;

  // Front: compare each report against the stored one, update the stored
  // state at the transfer and queue the work if anything changed.
  hidrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_axes    (s_tdata[39:0]),
    .in_hat_low (s_tdata[47:40]),
    .in_high    (s_tdata[55:48]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  // Hold pending work so new reports keep flowing while events drain.
  hidrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  // Back: walk the axes, hat and changed buttons of one report in order,
  // one event per output transfer.
  hidrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_axes  (out_axes),
    .out_last  (m_tlast)
  );

  // Pack the event; the top two bits fill the last byte.
  assign m_tdata = {2'b00, out_axes, out_value, out_kind};

endmodule

/* dv/tb_hid_report_change_events.sv */
`timescale 1ns / 100ps

module tb_hid_report_change_events;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  // One gamepad report as the testbench sees it: axis 0 in the low byte,
  // buttons 1..12 in bits 0..11 of the mask.
  typedef struct packed {
    logic [11:0] buttons;
    logic [3:0]  hat;
    logic [39:0] axes;
  } report_t;

  // One predicted event.
  typedef struct packed {
    hidrc_pkg::event_kind_t kind;
    logic [3:0]             value;
    logic [39:0]            axes;
    logic                   last;
  } gp_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // axis_x[7:0], axis_y[15:8], axis_z1[23:16], axis_z2[31:24], axis_rz[39:32],
  // hat_and_low_buttons[47:40], high_buttons[55:48]
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // event_kind[1:0], event_value[5:2], out_x[13:6], out_y[21:14],
  // out_z1[29:22], out_z2[37:30], out_rz[45:38], zero[47:46]
  logic [47:0] m_tdata;
  logic        m_tlast;

  hid_report_change_events dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Shadow copy of what the block remembers between reports.
  logic [39:0] held_axes = {hidrc_pkg::AXIS_COUNT{hidrc_pkg::AXIS_RESET}};
  logic [7:0]  held_hat = 8'hDE;
  logic [11:0] held_buttons = '0;

  gp_event_t pending_events[$];
  report_t   last_sent = '0;

  logic sender_gaps = 1'b1;
  logic sink_stalls = 1'b1;

  int cycle_count = 0;
  int error_count = 0;
  int reports_sent = 0;
  int events_seen = 0;
  int kind_seen[4] = '{0, 0, 0, 0};

  function automatic report_t make_report(input logic [39:0] axes, input logic [3:0] hat,
                                          input logic [11:0] buttons);
    report_t r;
    r.axes = axes;
    r.hat = hat;
    r.buttons = buttons;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    error_count++;
    $display("[%0t] MISMATCH %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // Work out the events one report causes, in the order the block sends them,
  // and advance the shadow state.
  task automatic predict_events(input report_t r);
    gp_event_t evs[14];
    int n;
    n = 0;
    if (r.axes != held_axes) begin
      evs[n] = '{kind: hidrc_pkg::EVENT_AXES, value: 4'd0, axes: r.axes, last: 1'b0};
      n++;
      held_axes = r.axes;
    end
    if ({4'h0, r.hat} != held_hat) begin
      evs[n] = '{kind: hidrc_pkg::EVENT_HAT, value: r.hat, axes: '0, last: 1'b0};
      n++;
      held_hat = {4'h0, r.hat};
    end
    for (int i = 0; i < hidrc_pkg::BUTTON_COUNT; i++) begin
      if (r.buttons[i] != held_buttons[i]) begin
        evs[n] = '{kind: (r.buttons[i] ? hidrc_pkg::EVENT_DOWN : hidrc_pkg::EVENT_UP),
                   value: 4'(i + 1), axes: '0, last: 1'b0};
        n++;
      end
    end
    held_buttons = r.buttons;
    for (int k = 0; k < n; k++) begin
      evs[k].last = (k == n - 1);
      pending_events.push_back(evs[k]);
    end
  endtask

  // Offer one report, hold it until the block takes it, then predict.
  task automatic send_report(input report_t r);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r.buttons[11:4], r.buttons[3:0], r.hat, r.axes};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_events(r);
    last_sent = r;
    reports_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted event has come out.
  task automatic wait_drained;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Random backpressure in short bursts.
  always begin
    @(negedge clk);
    if (sink_stalls && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    m_tready <= 1'b1;
  end

  // Compare each event transfer with the oldest prediction.
  always @(posedge clk) begin : check_events
    gp_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      events_seen++;
      kind_seen[m_tdata[1:0]]++;
      if (pending_events.size() == 0) begin
        flag_mismatch("event with nothing pending", 64'({m_tlast, m_tdata}), 64'd0);
      end else begin
        want = pending_events.pop_front();
        if (m_tdata[1:0] != want.kind)
          flag_mismatch("event_kind", 64'(m_tdata[1:0]), 64'(want.kind));
        if (m_tdata[5:2] != want.value)
          flag_mismatch("event_value", 64'(m_tdata[5:2]), 64'(want.value));
        for (int a = 0; a < hidrc_pkg::AXIS_COUNT; a++) begin
          if (m_tdata[6 + 8 * a +: 8] != want.axes[8 * a +: 8])
            flag_mismatch($sformatf("axis %0d", a), 64'(m_tdata[6 + 8 * a +: 8]),
                          64'(want.axes[8 * a +: 8]));
        end
        if (m_tdata[47:46] != 2'b00)
          flag_mismatch("pad bits", 64'(m_tdata[47:46]), 64'd0);
        if (m_tlast != want.last)
          flag_mismatch("last_event", 64'(m_tlast), 64'(want.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d events still pending", cycle_count,
               pending_events.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // First report after reset: the stored hat is unseen, so a hat event always comes;
  // axes equal to the reset bytes raise no axes event.
  task automatic test_first_report;
    send_report(make_report({hidrc_pkg::AXIS_COUNT{hidrc_pkg::AXIS_RESET}}, 4'h0, 12'h000));
    wait_drained();
  endtask

  // Repeating the stored report yields nothing.
  task automatic test_unchanged_report;
    send_report(last_sent);
    send_report(last_sent);
    wait_drained();
  endtask

  // Extremes of every field, each axis alone, the hat alone, alternating buttons.
  task automatic test_field_extremes;
    report_t r;
    send_report(make_report('1, 4'hF, 12'hFFF));
    send_report(make_report('0, 4'h0, 12'h000));
    r = last_sent;
    for (int a = 0; a < hidrc_pkg::AXIS_COUNT; a++) begin
      r.axes[8 * a +: 8] = 8'h80 + 8'(a);
      send_report(r);
    end
    r.hat = 4'h9;
    send_report(r);
    r.buttons = 12'h555;
    send_report(r);
    r.buttons = 12'hAAA;
    send_report(r);
    wait_drained();
  endtask

  // Mostly small edits of the last report, with some repeats and some fully random.
  task automatic test_random_reports(input int count, input int drain_at);
    report_t r;
    logic [11:0] flips;
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i == drain_at) wait_drained();
      r = last_sent;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        r.axes = 40'({$urandom, $urandom});
        r.hat = 4'($urandom);
        r.buttons = 12'($urandom);
      end else if (pick < 17) begin
        if ($urandom_range(0, 2) == 0) r.axes[8 * $urandom_range(0, 4) +: 8] = 8'($urandom);
        if ($urandom_range(0, 3) == 0) r.hat = 4'($urandom);
        flips = 12'($urandom & $urandom & $urandom);
        r.buttons = r.buttons ^ flips;
      end
      send_report(r);
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_first_report();
    test_unchanged_report();
    test_field_extremes();
    test_random_reports(200, 90);

    // Quiet tail: back-to-back transfers on both sides.
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random_reports(55, -1);

    if (pending_events.size() != 0) begin
      error_count++;
      $display("%0d predicted events never arrived", pending_events.size());
    end
    $display("Covered %0d reports, %0d events: %0d axes, %0d hat, %0d down, %0d up",
             reports_sent, events_seen, kind_seen[0], kind_seen[1], kind_seen[2],
             kind_seen[3]);
    $display("Stimulus: reset report, repeats, field extremes, random edits, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
